FILE: rtl/cgde_pkg.sv
`timescale 1ns / 1ps

package cgde_pkg;

    // Grid size defaults
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 64;

    // Field widths
    localparam int COORD_W   = 16;
    localparam int CHAR_W    = 8;
    localparam int COUNT_W   = 4;
    localparam int WIDTH_W   = 8;
    localparam int HEIGHT_W  = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;
    localparam int IN_DATA_W = 72;
    localparam int OUT_DATA_W = 16;

    // Reset values of the registers
    localparam logic [CHAR_W-1:0]   RESET_BG     = 8'd32;
    localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 8'd80;
    localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 7'd24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 2'd2;

    // Command codes; code 7 is unused and answers with an all-zero word
    typedef enum logic [2:0] {
        MODE_WRITE = 3'd0,
        MODE_READ  = 3'd1,
        MODE_HLINE = 3'd2,
        MODE_VLINE = 3'd3,
        MODE_BOX   = 3'd4,
        MODE_NBR   = 3'd5,
        MODE_CLEAR = 3'd6
    } mode_t;

    typedef struct packed {
        logic [COORD_W-1:0] val;
        logic               hit;
    } sat_t;

    // Saturate a signed coordinate into 0..maxv and flag it
    function automatic sat_t sat_coord(input logic [COORD_W-1:0] v,
                                       input logic [COORD_W-1:0] maxv);
        sat_t r;
        r.val = v;
        r.hit = 1'b0;
        if (v[COORD_W-1]) begin
            r.val = '0;
            r.hit = 1'b1;
        end else if (v > maxv) begin
            r.val = maxv;
            r.hit = 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: rtl/char_grid_draw_engine_unit.sv
`timescale 1ns / 1ps

// Character-cell draw engine. The grid of 8-bit cells lives in one synchronous
// RAM of 2^(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) entries, addressed {row, column},
// with one write port and one read port whose read data is registered.
// After reset the block first sweeps the whole RAM writing the space character,
// one entry a cycle; s_tready stays low during that pass, while configuration
// writes are taken as usual. Each command word on the slave side yields exactly
// one result word on the master side. A read issues one RAM read; a neighbor
// count does a setup step and then eight RAM reads back to back; write,
// hline/vline/box and clear (width*height cells) write their cells one per
// cycle through the single write port, and that port sets the drawing rate.
// Unused code 7 touches no cell and goes straight to the result.
// A finished result sits in the output register, so a new command can be
// taken while the previous result still waits for m_tready; a command that
// finishes while that register is still full holds in a wait state.
// Coordinates are saturated into the in-use area and bit 12 of the result
// reports it. Configuration must only be written while the block is idle.

module char_grid_draw_engine_unit #(
    parameter int MAX_WIDTH  = cgde_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cgde_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [cgde_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cgde_pkg::CFG_DAT_W-1:0]  cfg_data,
    // command stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // x_a[15:0], y_a[31:16], x_b[47:32], y_b[63:48], cell_char[71:64]
    input  logic [cgde_pkg::IN_DATA_W-1:0]  s_tdata,
    // mode[2:0]
    input  logic [2:0]                      s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_char[7:0], neighbor_count[11:8], clamped[12], zero[15:13]
    output logic [cgde_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int XW     = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ADDR_W = XW + YW;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int CW     = (WW > cgde_pkg::WIDTH_W)  ? WW : cgde_pkg::WIDTH_W;
    localparam int CH     = (HW > cgde_pkg::HEIGHT_W) ? HW : cgde_pkg::HEIGHT_W;

    typedef enum logic [7:0] {
        ST_CLR  = 8'b0000_0001,
        ST_IDLE = 8'b0000_0010,
        ST_FILL = 8'b0000_0100,
        ST_RD   = 8'b0000_1000,
        ST_RDW  = 8'b0001_0000,
        ST_NBS  = 8'b0010_0000,
        ST_NB   = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [cgde_pkg::CHAR_W-1:0]   bg_reg;
    logic [cgde_pkg::WIDTH_W-1:0]  width_reg;
    logic [cgde_pkg::HEIGHT_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            bg_reg     <= cgde_pkg::RESET_BG;
            width_reg  <= cgde_pkg::RESET_WIDTH;
            height_reg <= cgde_pkg::RESET_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cgde_pkg::REG_BACKGROUND: bg_reg     <= cfg_data;
                cgde_pkg::REG_WIDTH:      width_reg  <= cfg_data;
                cgde_pkg::REG_HEIGHT:     height_reg <= cfg_data[cgde_pkg::HEIGHT_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Effective size, saturated into 1..MAX
    logic [CW-1:0] w_ext, w_eff, w_m1;
    logic [CH-1:0] h_ext, h_eff, h_m1;
    logic [XW-1:0] x_max;
    logic [YW-1:0] y_max;

    always_comb
    begin
        w_ext = CW'(width_reg);
        h_ext = CH'(height_reg);
        if (w_ext == '0)
            w_eff = CW'(1);
        else if (w_ext > CW'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = w_ext;
        if (h_ext == '0)
            h_eff = CH'(1);
        else if (h_ext > CH'(MAX_HEIGHT))
            h_eff = CH'(MAX_HEIGHT);
        else
            h_eff = h_ext;
        w_m1  = w_eff - CW'(1);
        h_m1  = h_eff - CH'(1);
        x_max = w_m1[XW-1:0];
        y_max = h_m1[YW-1:0];
    end

    // ---------------------------------------------------------------
    // Command decode: saturate, order the corners, pick the used flags
    // ---------------------------------------------------------------
    cgde_pkg::mode_t in_mode;
    cgde_pkg::sat_t  sat_xa, sat_ya, sat_xb, sat_yb;
    logic [XW-1:0]   sxa, sxb, new_x0, new_x1;
    logic [YW-1:0]   sya, syb, new_y0, new_y1;
    logic [cgde_pkg::CHAR_W-1:0] new_char;
    logic            new_clamp;

    always_comb
    begin
        in_mode = cgde_pkg::mode_t'(s_tuser);
        sat_xa  = cgde_pkg::sat_coord(s_tdata[15:0],  16'(x_max));
        sat_ya  = cgde_pkg::sat_coord(s_tdata[31:16], 16'(y_max));
        sat_xb  = cgde_pkg::sat_coord(s_tdata[47:32], 16'(x_max));
        sat_yb  = cgde_pkg::sat_coord(s_tdata[63:48], 16'(y_max));
        sxa     = sat_xa.val[XW-1:0];
        sxb     = sat_xb.val[XW-1:0];
        sya     = sat_ya.val[YW-1:0];
        syb     = sat_yb.val[YW-1:0];
        new_x0  = sxa;
        new_x1  = sxa;
        new_y0  = sya;
        new_y1  = sya;
        new_char  = s_tdata[71:64];
        new_clamp = sat_xa.hit | sat_ya.hit;
        unique case (in_mode) inside
            cgde_pkg::MODE_HLINE:
            begin
                new_x0    = (sxa < sxb) ? sxa : sxb;
                new_x1    = (sxa < sxb) ? sxb : sxa;
                new_clamp = sat_xa.hit | sat_xb.hit | sat_ya.hit;
            end
            cgde_pkg::MODE_VLINE:
            begin
                new_y0    = (sya < syb) ? sya : syb;
                new_y1    = (sya < syb) ? syb : sya;
                new_clamp = sat_xa.hit | sat_ya.hit | sat_yb.hit;
            end
            cgde_pkg::MODE_BOX:
            begin
                new_x0    = (sxa < sxb) ? sxa : sxb;
                new_x1    = (sxa < sxb) ? sxb : sxa;
                new_y0    = (sya < syb) ? sya : syb;
                new_y1    = (sya < syb) ? syb : sya;
                new_clamp = sat_xa.hit | sat_xb.hit | sat_ya.hit | sat_yb.hit;
            end
            cgde_pkg::MODE_CLEAR:
            begin
                new_x0    = '0;
                new_x1    = x_max;
                new_y0    = '0;
                new_y1    = y_max;
                new_char  = bg_reg;
                new_clamp = 1'b0;
            end
            cgde_pkg::MODE_WRITE, cgde_pkg::MODE_READ, cgde_pkg::MODE_NBR: ;
            default:
                new_clamp = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    state_t                      state_reg, state_next;
    logic [ADDR_W-1:0]           clr_cnt_reg;
    logic [XW-1:0]               x0_reg, x1_reg, cx_reg;
    logic [YW-1:0]               y0_reg, y1_reg, cy_reg;
    logic [cgde_pkg::CHAR_W-1:0] char_reg, rd_reg;
    logic [cgde_pkg::COUNT_W-1:0] nb_cnt_reg, nb_k_reg;
    logic                        clamp_reg;
    logic                        m_tvalid_reg;
    logic [cgde_pkg::OUT_DATA_W-1:0] m_data_reg;

    logic                        mem_we, mem_re;
    logic [ADDR_W-1:0]           mem_waddr, mem_raddr;
    logic [cgde_pkg::CHAR_W-1:0] mem_wdata, mem_rdata_reg;

    logic                        accept, out_free, fin, load_out, nb_hit;
    logic [cgde_pkg::CHAR_W-1:0] fin_rd;
    logic [cgde_pkg::COUNT_W-1:0] fin_nb, nb_sum;
    logic [XW-1:0]               nb_x;
    logic [YW-1:0]               nb_y;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    // Neighbor k of eight: x0/x1 hold column left/right, y0/y1 row above/below
    always_comb
    begin
        case (nb_k_reg[2:0])
            3'd0:    begin nb_x = x0_reg; nb_y = y0_reg; end
            3'd1:    begin nb_x = cx_reg; nb_y = y0_reg; end
            3'd2:    begin nb_x = x1_reg; nb_y = y0_reg; end
            3'd3:    begin nb_x = x0_reg; nb_y = cy_reg; end
            3'd4:    begin nb_x = x1_reg; nb_y = cy_reg; end
            3'd5:    begin nb_x = x0_reg; nb_y = y1_reg; end
            3'd6:    begin nb_x = cx_reg; nb_y = y1_reg; end
            default: begin nb_x = x1_reg; nb_y = y1_reg; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = {cy_reg, cx_reg};
        mem_wdata  = char_reg;
        mem_re     = 1'b0;
        mem_raddr  = {cy_reg, cx_reg};
        fin        = 1'b0;
        fin_rd     = rd_reg;
        fin_nb     = nb_cnt_reg;
        // the read issued last cycle lands now; nothing is in flight at k = 0
        nb_hit     = (nb_k_reg != '0) && (mem_rdata_reg != bg_reg);
        nb_sum     = nb_cnt_reg + cgde_pkg::COUNT_W'(nb_hit);
        unique case (state_reg)
            ST_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = cgde_pkg::RESET_BG;
                if (&clr_cnt_reg)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (in_mode) inside
                        cgde_pkg::MODE_READ: state_next = ST_RD;
                        cgde_pkg::MODE_NBR:  state_next = ST_NBS;
                        cgde_pkg::MODE_WRITE, cgde_pkg::MODE_HLINE, cgde_pkg::MODE_VLINE,
                        cgde_pkg::MODE_BOX, cgde_pkg::MODE_CLEAR:
                                             state_next = ST_FILL;
                        default:             state_next = ST_DONE;
                    endcase
                end
            end
            ST_FILL:
            begin
                mem_we = 1'b1;
                fin    = (cx_reg == x1_reg) && (cy_reg == y1_reg);
            end
            ST_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_RDW;
            end
            ST_RDW:
            begin
                fin    = 1'b1;
                fin_rd = mem_rdata_reg;
            end
            ST_NBS:
                state_next = ST_NB;
            ST_NB:
            begin
                if (!nb_k_reg[cgde_pkg::COUNT_W-1])
                begin
                    mem_re    = 1'b1;
                    mem_raddr = {nb_y, nb_x};
                end
                else
                begin
                    fin    = 1'b1;
                    fin_nb = nb_sum;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
        if (fin)
            state_next = out_free ? ST_IDLE : ST_DONE;
    end

    assign load_out = (fin || (state_reg == ST_DONE)) && out_free;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLR)
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk) begin
        if (accept)
        begin
            x0_reg     <= new_x0;
            x1_reg     <= new_x1;
            y0_reg     <= new_y0;
            y1_reg     <= new_y1;
            cx_reg     <= new_x0;
            cy_reg     <= new_y0;
            char_reg   <= new_char;
            clamp_reg  <= new_clamp;
            rd_reg     <= '0;
            nb_cnt_reg <= '0;
        end
        unique case (state_reg)
            ST_FILL:
            begin
                // walk the rectangle row by row
                if (cx_reg == x1_reg)
                begin
                    cx_reg <= x0_reg;
                    cy_reg <= cy_reg + YW'(1);
                end
                else
                    cx_reg <= cx_reg + XW'(1);
            end
            ST_NBS:
            begin
                x0_reg   <= (cx_reg == '0)    ? x_max : cx_reg - XW'(1);
                x1_reg   <= (cx_reg == x_max) ? '0    : cx_reg + XW'(1);
                y0_reg   <= (cy_reg == '0)    ? y_max : cy_reg - YW'(1);
                y1_reg   <= (cy_reg == y_max) ? '0    : cy_reg + YW'(1);
                nb_k_reg <= '0;
            end
            ST_NB:
            begin
                if (!nb_k_reg[cgde_pkg::COUNT_W-1])
                begin
                    nb_cnt_reg <= nb_sum;
                    nb_k_reg   <= nb_k_reg + cgde_pkg::COUNT_W'(1);
                end
            end
            default: ;
        endcase
        // hold the result while the output register is still occupied
        if (fin && !out_free)
        begin
            rd_reg     <= fin_rd;
            nb_cnt_reg <= fin_nb;
        end
        if (load_out)
            m_data_reg <= {3'b000, clamp_reg, fin_nb, fin_rd};
    end

    // ---------------------------------------------------------------
    // Cell memory
    // ---------------------------------------------------------------
    logic [cgde_pkg::CHAR_W-1:0] grid_mem [DEPTH];

    always_ff @(posedge clk) begin
        if (mem_we)
            grid_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= grid_mem[mem_raddr];
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_fill_in_area: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (cx_reg <= x_max) && (cy_reg <= y_max))
        else $error("fill cursor left the in-use area");

    a_fill_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (cx_reg >= x0_reg) && (cx_reg <= x1_reg)
                                && (cy_reg >= y0_reg) && (cy_reg <= y1_reg))
        else $error("fill cursor left the drawn rectangle");

    a_clear_pass_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLR && (&clr_cnt_reg)) |=> (state_reg == ST_IDLE))
        else $error("reset clearing pass did not end in idle");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[11:8] <= 4'd8))
        else $error("neighbor count above eight");

    a_one_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:0] == '0) || (m_tdata[11:8] == '0))
        else $error("read data and neighbor count both set");

endmodule
